// ----- rtl/core/im2col_pkg.sv -----
`timescale 1ns / 1ps

package im2col_pkg;

  // field widths of the configuration registers and items
  localparam int CFG_W     = 11;
  localparam int KCFG_W    = 5;
  localparam int STRIDE_W  = 4;
  localparam int PAD_W     = 4;
  localparam int SRC_W     = 30;
  localparam int DST_W     = 39;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_AMOUNT    = 3'd6;

endpackage

// ----- rtl/core/im2col_mac.sv -----
`timescale 1ns / 1ps

module im2col_mac import im2col_pkg::*; #(
  parameter int A_W = 21,
  parameter int B_W = CFG_W,
  parameter int C_W = 16,
  parameter int P_W = ((A_W + B_W > C_W) ? A_W + B_W : C_W) + 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  input  logic [C_W-1:0] c_i,
  output logic [P_W-1:0] p_o
);

  logic [A_W+B_W-1:0] prod;
  logic [P_W-1:0]     p_q;

  // one multiply-add, result registered
  assign prod = (A_W + B_W)'(a_i) * (A_W + B_W)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= P_W'(prod) + P_W'(c_i);
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/im2col_div.sv -----
`timescale 1ns / 1ps

module im2col_div import im2col_pkg::*; #(
  parameter int N_W = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [N_W-1:0]      dividend_i,
  input  logic [STRIDE_W-1:0] divisor_i,
  output logic                done_o,
  output logic [N_W-1:0]      quot_o
);

  localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STRIDE_W-1:0] rem_q;
  logic [N_W-1:0]      quo_q;
  logic [STRIDE_W:0]   trial;
  logic                ge;

  // restoring step: bring down the next dividend bit
  assign trial = {rem_q, quo_q[N_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // remainder and shifting dividend / quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? STRIDE_W'(trial - {1'b0, divisor_i}) : STRIDE_W'(trial);
      quo_q <= {quo_q[N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/core/im2col_address_generator_top.sv -----
`timescale 1ns / 1ps

// im2col gather address generator. Each input item gives exactly one result item: the image
// offset to read, the column-matrix index, a zero-pad flag, a last mark and a valid flag,
// walking out_col fastest, then out_row, kernel column, kernel row and channel. An item
// that advances goes through the row, column, plane, address and emit states before the
// next acceptance: the address is built by one shared multiply-add unit used four times
// in a row (row, column, channel plane, final offset). A restart item also works out the
// output height and width with a bit-serial divider, one quotient bit per cycle, before
// its walk. Configuration is read live for each item; the output size is latched at
// restart. A result waits in the output register while the next item is accepted.
module im2col_address_generator_top import im2col_pkg::*; #(
  parameter int MAX_DIM      = 1024,
  parameter int MAX_KERNEL   = 16,
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SRC_W-1:0]     src_addr_o,
  output logic [DST_W-1:0]     dst_index_o,
  output logic                 pad_zero_o,
  output logic                 last_elem_o,
  output logic                 elem_valid_o
);

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int KER_MAX = (1 << KCFG_W) - 1;
  localparam int PAD_MAX = (1 << PAD_W) - 1;
  localparam int NCH_CAP = (MAX_CHANNELS > CFG_MAX) ? CFG_MAX : MAX_CHANNELS;
  localparam int DIM_CAP = (MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM;
  localparam int KER_CAP = (MAX_KERNEL > KER_MAX) ? KER_MAX : MAX_KERNEL;
  localparam int CH_W    = (NCH_CAP > 1) ? $clog2(NCH_CAP) : 1;
  localparam int KR_W    = (KER_CAP > 1) ? $clog2(KER_CAP) : 1;
  localparam int SPAN_W  = $clog2(DIM_CAP + 2 * PAD_MAX + 1);
  localparam int OW      = SPAN_W;
  localparam int POS_W   = OW + STRIDE_W + 1;
  localparam int T_W     = CFG_W + CH_W;
  localparam int A_W     = (T_W > OW) ? T_W : OW;
  localparam int C_W     = POS_W;
  localparam int P_W     = ((A_W + CFG_W > C_W) ? A_W + CFG_W : C_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_H,
    S_DIV_W,
    S_ROW,
    S_COL,
    S_PLANE,
    S_ADDR,
    S_EMIT
  } state_e;

  // configuration registers
  logic [CFG_W-1:0]    chan_count_q, img_h_q, img_w_q;
  logic [KCFG_W-1:0]   ker_h_q, ker_w_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [PAD_W-1:0]    pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= CFG_W'(1);
      img_h_q      <= CFG_W'(1);
      img_w_q      <= CFG_W'(1);
      ker_h_q      <= KCFG_W'(1);
      ker_w_q      <= KCFG_W'(1);
      stride_q     <= STRIDE_W'(1);
      pad_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHANNEL_COUNT: chan_count_q <= cfg_data_i;
        REG_IMAGE_HEIGHT:  img_h_q      <= cfg_data_i;
        REG_IMAGE_WIDTH:   img_w_q      <= cfg_data_i;
        REG_KERNEL_HEIGHT: ker_h_q      <= cfg_data_i[KCFG_W-1:0];
        REG_KERNEL_WIDTH:  ker_w_q      <= cfg_data_i[KCFG_W-1:0];
        REG_STRIDE_STEP:   stride_q     <= cfg_data_i[STRIDE_W-1:0];
        REG_PAD_AMOUNT:    pad_q        <= cfg_data_i[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  state_e           state_q;
  logic [CH_W-1:0]  chan_idx_q;
  logic [KR_W-1:0]  kern_row_q, kern_col_q;
  logic [OW-1:0]    out_row_q, out_col_q, out_height_q, out_width_q;
  logic [DST_W-1:0] dst_q;
  logic             pass_active_q;
  logic             elem_q, inside_q;
  logic [POS_W-1:0] pos_r_q, pos_c_q;
  logic             out_valid_q, pad_zero_q, last_elem_q, elem_valid_q;
  logic [SRC_W-1:0] src_addr_q;
  logic [DST_W-1:0] dst_index_q;

  // saturated live configuration
  logic [CFG_W-1:0]    nch, ih, iw;
  logic [KCFG_W-1:0]   kh, kw;
  logic [STRIDE_W-1:0] st;

  assign nch = (chan_count_q > CFG_W'(NCH_CAP)) ? CFG_W'(NCH_CAP) : chan_count_q;
  assign ih  = (img_h_q > CFG_W'(DIM_CAP)) ? CFG_W'(DIM_CAP) : img_h_q;
  assign iw  = (img_w_q > CFG_W'(DIM_CAP)) ? CFG_W'(DIM_CAP) : img_w_q;
  assign kh  = (ker_h_q > KCFG_W'(KER_CAP)) ? KCFG_W'(KER_CAP) : ker_h_q;
  assign kw  = (ker_w_q > KCFG_W'(KER_CAP)) ? KCFG_W'(KER_CAP) : ker_w_q;
  assign st  = (stride_q == '0) ? STRIDE_W'(1) : stride_q;

  // output size dividends: padded span minus kernel
  logic [SPAN_W-1:0] span_h, span_w, num_h, num_w;
  logic              empty_h, empty_w;

  assign span_h  = SPAN_W'(ih) + SPAN_W'({pad_q, 1'b0});
  assign span_w  = SPAN_W'(iw) + SPAN_W'({pad_q, 1'b0});
  assign empty_h = (kh == '0) || (span_h < SPAN_W'(kh));
  assign empty_w = (kw == '0) || (span_w < SPAN_W'(kw));
  assign num_h   = empty_h ? '0 : span_h - SPAN_W'(kh);
  assign num_w   = empty_w ? '0 : span_w - SPAN_W'(kw);

  logic              in_accept, slot_free;
  logic              div_start, div_done;
  logic [SPAN_W-1:0] div_num, div_quot;
  logic [OW-1:0]     out_width_d;

  assign in_accept = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign div_start = ((state_q == S_IDLE) && in_accept && restart_i) ||
                     ((state_q == S_DIV_H) && div_done);
  assign div_num   = (state_q == S_IDLE) ? num_h : num_w;
  assign out_width_d = empty_w ? '0 : OW'(div_quot) + 1'b1;

  im2col_div #(
    .N_W(SPAN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (st),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // shared multiply-add operand selection
  logic             mac_en;
  logic [A_W-1:0]   mac_a;
  logic [CFG_W-1:0] mac_b;
  logic [C_W-1:0]   mac_c;
  logic [P_W-1:0]   mac_p;
  logic [POS_W-1:0] row_pos, col_pos;

  assign row_pos = pos_r_q - POS_W'(pad_q);
  assign col_pos = pos_c_q - POS_W'(pad_q);

  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = '0;
    unique case (state_q)
      S_ROW: begin
        mac_en = pass_active_q;
        mac_a  = A_W'(out_row_q);
        mac_b  = CFG_W'(st);
        mac_c  = C_W'(kern_row_q);
      end
      S_COL: begin
        mac_en = 1'b1;
        mac_a  = A_W'(out_col_q);
        mac_b  = CFG_W'(st);
        mac_c  = C_W'(kern_col_q);
      end
      S_PLANE: begin
        mac_en = 1'b1;
        mac_a  = A_W'(chan_idx_q);
        mac_b  = ih;
        mac_c  = row_pos;
      end
      S_ADDR: begin
        mac_en = 1'b1;
        mac_a  = A_W'(mac_p);
        mac_b  = iw;
        mac_c  = col_pos;
      end
      default: ;
    endcase
  end

  im2col_mac #(
    .A_W(A_W),
    .B_W(CFG_W),
    .C_W(C_W),
    .P_W(P_W)
  ) u_mac (
    .clk_i(clk_i),
    .en_i (mac_en),
    .a_i  (mac_a),
    .b_i  (mac_b),
    .c_i  (mac_c),
    .p_o  (mac_p)
  );

  // bounds check against the image, border positions read as zero
  logic row_in, col_in;
  assign row_in = (pos_r_q >= POS_W'(pad_q)) && (row_pos < POS_W'(ih));
  assign col_in = (pos_c_q >= POS_W'(pad_q)) && (col_pos < POS_W'(iw));

  // counter wrap flags for the nested walk
  logic wrap_c, wrap_r, wrap_kc, wrap_kr, wrap_ch, last_w;
  assign wrap_c  = 32'(out_col_q) + 32'd1 >= 32'(out_width_q);
  assign wrap_r  = 32'(out_row_q) + 32'd1 >= 32'(out_height_q);
  assign wrap_kc = 32'(kern_col_q) + 32'd1 >= 32'(kw);
  assign wrap_kr = 32'(kern_row_q) + 32'd1 >= 32'(kh);
  assign wrap_ch = 32'(chan_idx_q) + 32'd1 >= 32'(nch);
  assign last_w  = wrap_c && wrap_r && wrap_kc && wrap_kr && wrap_ch;

  // sequencer, walk counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chan_idx_q    <= '0;
      kern_row_q    <= '0;
      kern_col_q    <= '0;
      out_row_q     <= '0;
      out_col_q     <= '0;
      out_height_q  <= '0;
      out_width_q   <= '0;
      dst_q         <= '0;
      pass_active_q <= 1'b0;
      elem_q        <= 1'b0;
      inside_q      <= 1'b0;
      pos_r_q       <= '0;
      pos_c_q       <= '0;
      out_valid_q   <= 1'b0;
      elem_valid_q  <= 1'b0;
      src_addr_q    <= '0;
      dst_index_q   <= '0;
      pad_zero_q    <= 1'b0;
      last_elem_q   <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (restart_i) begin
              chan_idx_q <= '0;
              kern_row_q <= '0;
              kern_col_q <= '0;
              out_row_q  <= '0;
              out_col_q  <= '0;
              dst_q      <= '0;
              state_q    <= S_DIV_H;
            end else begin
              state_q <= S_ROW;
            end
          end
        end
        S_DIV_H: begin
          if (div_done) begin
            out_height_q <= empty_h ? '0 : OW'(div_quot) + 1'b1;
            state_q      <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            out_width_q   <= out_width_d;
            pass_active_q <= (out_height_q != '0) && (out_width_d != '0) && (nch != '0);
            state_q       <= S_ROW;
          end
        end
        S_ROW: begin
          elem_q  <= pass_active_q;
          state_q <= pass_active_q ? S_COL : S_EMIT;
        end
        S_COL: begin
          pos_r_q <= POS_W'(mac_p);
          state_q <= S_PLANE;
        end
        S_PLANE: begin
          pos_c_q <= POS_W'(mac_p);
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          inside_q <= row_in && col_in;
          state_q  <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            elem_valid_q <= elem_q;
            src_addr_q   <= (elem_q && inside_q) ? SRC_W'(mac_p) : '0;
            dst_index_q  <= elem_q ? dst_q : '0;
            pad_zero_q   <= elem_q && !inside_q;
            last_elem_q  <= elem_q && last_w;
            state_q      <= S_IDLE;
            if (elem_q) begin
              dst_q <= dst_q + 1'b1;
              if (last_w) begin
                pass_active_q <= 1'b0;
              end else if (!wrap_c) begin
                out_col_q <= out_col_q + 1'b1;
              end else begin
                out_col_q <= '0;
                if (!wrap_r) begin
                  out_row_q <= out_row_q + 1'b1;
                end else begin
                  out_row_q <= '0;
                  if (!wrap_kc) begin
                    kern_col_q <= kern_col_q + 1'b1;
                  end else begin
                    kern_col_q <= '0;
                    if (!wrap_kr) begin
                      kern_row_q <= kern_row_q + 1'b1;
                    end else begin
                      kern_row_q <= '0;
                      chan_idx_q <= chan_idx_q + 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign src_addr_o   = src_addr_q;
  assign dst_index_o  = dst_index_q;
  assign pad_zero_o   = pad_zero_q;
  assign last_elem_o  = last_elem_q;
  assign elem_valid_o = elem_valid_q;

`ifndef SYNTH
  // an invalid item carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !elem_valid_o |->
      !pad_zero_o && !last_elem_o && src_addr_o == '0 && dst_index_o == '0)
    else $error("invalid item with nonzero fields");

  // a border element reads nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_zero_o |-> src_addr_o == '0 && elem_valid_o)
    else $error("pad element with source address");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_H || state_q == S_DIV_W)
    else $error("divider done outside size setup");

  // once the last element is out and nothing new started, the pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_elem_o && state_q == S_IDLE |-> !pass_active_q)
    else $error("pass still active after last element");

  // an accepted item always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted item not processed");
`endif

endmodule
